FILE: rtl/sct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants of the source code tokenizer: scan modes, token
// kinds, separator and operator codes, and the default position widths.
// ----------------------------------------------------------------------------
package sct_pkg;

	// default widths of the position counters
	localparam int OFFSET_BITS_DEF = 24;
	localparam int LINE_BITS_DEF   = 16;

	// entries in the result queue (power of two, at least two)
	localparam int RES_DEPTH = 4;

	localparam int KIND_W = 3;
	localparam int CODE_W = 6;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_IDENT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SEP   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_OP    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INT   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DEC   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd5;

	// separator codes
	localparam logic [CODE_W-1:0] CODE_NONE    = 6'd0;
	localparam logic [CODE_W-1:0] SEP_LPAREN   = 6'd0;
	localparam logic [CODE_W-1:0] SEP_RPAREN   = 6'd1;
	localparam logic [CODE_W-1:0] SEP_LBRACE   = 6'd2;
	localparam logic [CODE_W-1:0] SEP_RBRACE   = 6'd3;
	localparam logic [CODE_W-1:0] SEP_LBRACKET = 6'd4;
	localparam logic [CODE_W-1:0] SEP_RBRACKET = 6'd5;
	localparam logic [CODE_W-1:0] SEP_COLON    = 6'd6;
	localparam logic [CODE_W-1:0] SEP_SEMI     = 6'd7;

	// symbol codes
	localparam logic [CODE_W-1:0] SYM_COMMA    = 6'd8;
	localparam logic [CODE_W-1:0] SYM_QUEST    = 6'd9;
	localparam logic [CODE_W-1:0] SYM_ELLIPSIS = 6'd10;
	localparam logic [CODE_W-1:0] SYM_DOT      = 6'd11;
	localparam logic [CODE_W-1:0] SYM_DIV_EQ   = 6'd12;
	localparam logic [CODE_W-1:0] SYM_DIV      = 6'd13;
	localparam logic [CODE_W-1:0] SYM_INC      = 6'd14;
	localparam logic [CODE_W-1:0] SYM_ADD_EQ   = 6'd15;
	localparam logic [CODE_W-1:0] SYM_ADD      = 6'd16;
	localparam logic [CODE_W-1:0] SYM_DECR     = 6'd17;
	localparam logic [CODE_W-1:0] SYM_SUB_EQ   = 6'd18;
	localparam logic [CODE_W-1:0] SYM_SUB      = 6'd19;
	localparam logic [CODE_W-1:0] SYM_MUL_EQ   = 6'd20;
	localparam logic [CODE_W-1:0] SYM_MUL      = 6'd21;
	localparam logic [CODE_W-1:0] SYM_MOD_EQ   = 6'd22;
	localparam logic [CODE_W-1:0] SYM_MOD      = 6'd23;
	localparam logic [CODE_W-1:0] SYM_GE       = 6'd24;
	localparam logic [CODE_W-1:0] SYM_USHR_EQ  = 6'd25;
	localparam logic [CODE_W-1:0] SYM_USHR     = 6'd26;
	localparam logic [CODE_W-1:0] SYM_SHR_EQ   = 6'd27;
	localparam logic [CODE_W-1:0] SYM_SHR      = 6'd28;
	localparam logic [CODE_W-1:0] SYM_GT       = 6'd29;
	localparam logic [CODE_W-1:0] SYM_LE       = 6'd30;
	localparam logic [CODE_W-1:0] SYM_SHL_EQ   = 6'd31;
	localparam logic [CODE_W-1:0] SYM_SHL      = 6'd32;
	localparam logic [CODE_W-1:0] SYM_LT       = 6'd33;
	localparam logic [CODE_W-1:0] SYM_EQ_EQ    = 6'd34;
	localparam logic [CODE_W-1:0] SYM_ARROW    = 6'd35;
	localparam logic [CODE_W-1:0] SYM_ASSIGN   = 6'd36;
	localparam logic [CODE_W-1:0] SYM_NE       = 6'd37;
	localparam logic [CODE_W-1:0] SYM_NOT      = 6'd38;
	localparam logic [CODE_W-1:0] SYM_LOR      = 6'd39;
	localparam logic [CODE_W-1:0] SYM_OR_EQ    = 6'd40;
	localparam logic [CODE_W-1:0] SYM_OR       = 6'd41;
	localparam logic [CODE_W-1:0] SYM_LAND     = 6'd42;
	localparam logic [CODE_W-1:0] SYM_AND_EQ   = 6'd43;
	localparam logic [CODE_W-1:0] SYM_AND      = 6'd44;
	localparam logic [CODE_W-1:0] SYM_XOR_EQ   = 6'd45;
	localparam logic [CODE_W-1:0] SYM_XOR      = 6'd46;
	localparam logic [CODE_W-1:0] SYM_TILDE    = 6'd47;

	// characters with a role of their own
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	// scan modes
	typedef enum logic [4:0] {
		M_IDLE, M_IDENT, M_SLASH, M_LCOM, M_BCOM, M_ZERO, M_INT, M_DEC, M_DOT,
		M_DOT2, M_PLUS, M_MINUS, M_STAR, M_PCT, M_GT, M_GT2, M_GT3, M_LT,
		M_LT2, M_EQ, M_BANG, M_BAR, M_AMP, M_CARET
	} mode_t;

	// results written into the queue by one step
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

FILE: rtl/sct_scan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_scan_core
// Scan state and position counters, with the combinational step logic that
// turns one character into up to two tokens.
// ----------------------------------------------------------------------------
module sct_scan_core #(
	parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF,
	parameter int LINE_BITS   = sct_pkg::LINE_BITS_DEF,
	parameter int RES_W       = sct_pkg::KIND_W + sct_pkg::CODE_W
	                            + 2 * OFFSET_BITS + 2 * LINE_BITS + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       char_in,
	input  logic             end_of_input,
	output sct_pkg::push_t   push,
	output logic [RES_W-1:0] res0,
	output logic [RES_W-1:0] res1
);

	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

	sct_pkg::mode_t         mode_q, mode_nx;
	logic [OFFSET_BITS-1:0] off_q, off_nx;
	logic [LINE_BITS-1:0]   line_q, line_nx;
	logic [LINE_BITS-1:0]   col_q, col_nx;
	logic [OFFSET_BITS-1:0] p_off_q, p_off_nx;
	logic [LINE_BITS-1:0]   p_line_q, p_line_nx;
	logic [LINE_BITS-1:0]   p_col_q, p_col_nx;
	logic                   star_q, star_nx;

	function automatic logic [OFFSET_BITS-1:0] inc_off(input logic [OFFSET_BITS-1:0] v);
		return (&v) ? v : v + OFFSET_BITS'(1);
	endfunction

	function automatic logic [LINE_BITS-1:0] inc_line(input logic [LINE_BITS-1:0] v);
		return (&v) ? v : v + LINE_BITS'(1);
	endfunction

	// step logic
	always_comb begin
		logic [7:0]             ch;
		logic                   letter, digit, nzdigit, consumed;
		logic                   a_valid, a_incl, b_valid;
		logic [2:0]             a_kind, b_kind;
		logic [5:0]             a_code, b_code;
		logic [OFFSET_BITS-1:0] here, after, a_end;
		logic [RES_W-1:0]       ra, rb;

		// a NUL matches nothing, so it stands for the end marker
		ch      = end_of_input ? 8'h00 : char_in;
		letter  = ch inside {["A":"Z"], ["a":"z"]};
		digit   = ch inside {[sct_pkg::CH_ZERO:sct_pkg::CH_NINE]};
		nzdigit = ch inside {["1":sct_pkg::CH_NINE]};
		here    = inc_off(off_q);
		after   = inc_off(here);

		consumed  = 1'b0;
		a_valid   = 1'b0;
		a_incl    = 1'b0;
		a_kind    = sct_pkg::KIND_OP;
		a_code    = sct_pkg::CODE_NONE;
		b_valid   = 1'b0;
		b_kind    = sct_pkg::KIND_OP;
		b_code    = sct_pkg::CODE_NONE;
		mode_nx   = mode_q;
		star_nx   = star_q;
		p_off_nx  = p_off_q;
		p_line_nx = p_line_q;
		p_col_nx  = p_col_q;

		// offer the character to the pending token
		case (mode_q)
			sct_pkg::M_IDLE: begin
				consumed = 1'b0;
			end
			sct_pkg::M_IDENT: begin
				if (letter || digit || ch == sct_pkg::CH_USCORE) begin
					consumed = 1'b1;
				end else begin
					a_valid = 1'b1;
					a_kind  = sct_pkg::KIND_IDENT;
					mode_nx = sct_pkg::M_IDLE;
				end
			end
			sct_pkg::M_SLASH: begin
				if (ch == "*") begin
					consumed = 1'b1;
					mode_nx  = sct_pkg::M_BCOM;
					star_nx  = 1'b0;
				end else if (ch == "/") begin
					consumed = 1'b1;
					mode_nx  = sct_pkg::M_LCOM;
				end else begin
					a_valid = 1'b1;
					mode_nx = sct_pkg::M_IDLE;
					if (ch == "=") begin
						consumed = 1'b1;
						a_incl   = 1'b1;
						a_code   = sct_pkg::SYM_DIV_EQ;
					end else begin
						a_code = sct_pkg::SYM_DIV;
					end
				end
			end
			sct_pkg::M_LCOM: begin
				consumed = 1'b1;
				if (ch == sct_pkg::CH_NEWLINE) begin
					mode_nx = sct_pkg::M_IDLE;
				end
			end
			sct_pkg::M_BCOM: begin
				consumed = 1'b1;
				if (star_q && ch == "/") begin
					mode_nx = sct_pkg::M_IDLE;
					star_nx = 1'b0;
				end else begin
					star_nx = (ch == "*");
				end
			end
			sct_pkg::M_ZERO: begin
				if (nzdigit) begin
					consumed = 1'b1;
					mode_nx  = sct_pkg::M_IDLE;
				end else if (ch == ".") begin
					consumed = 1'b1;
					mode_nx  = sct_pkg::M_DEC;
				end else begin
					a_valid = 1'b1;
					a_kind  = sct_pkg::KIND_INT;
					mode_nx = sct_pkg::M_IDLE;
				end
			end
			sct_pkg::M_INT: begin
				if (digit) begin
					consumed = 1'b1;
				end else if (ch == ".") begin
					consumed = 1'b1;
					mode_nx  = sct_pkg::M_DEC;
				end else begin
					a_valid = 1'b1;
					a_kind  = sct_pkg::KIND_INT;
					mode_nx = sct_pkg::M_IDLE;
				end
			end
			sct_pkg::M_DEC: begin
				if (digit) begin
					consumed = 1'b1;
				end else begin
					a_valid = 1'b1;
					a_kind  = sct_pkg::KIND_DEC;
					mode_nx = sct_pkg::M_IDLE;
				end
			end
			sct_pkg::M_DOT: begin
				if (digit) begin
					consumed = 1'b1;
					mode_nx  = sct_pkg::M_DEC;
				end else if (ch == ".") begin
					consumed = 1'b1;
					mode_nx  = sct_pkg::M_DOT2;
				end else begin
					a_valid = 1'b1;
					a_code  = sct_pkg::SYM_DOT;
					mode_nx = sct_pkg::M_IDLE;
				end
			end
			sct_pkg::M_DOT2: begin
				mode_nx = sct_pkg::M_IDLE;
				if (ch == ".") begin
					consumed = 1'b1;
					a_valid  = 1'b1;
					a_incl   = 1'b1;
					a_kind   = sct_pkg::KIND_SEP;
					a_code   = sct_pkg::SYM_ELLIPSIS;
				end
			end
			sct_pkg::M_PLUS: begin
				a_valid = 1'b1;
				mode_nx = sct_pkg::M_IDLE;
				if (ch == "+") begin
					consumed = 1'b1;
					a_incl   = 1'b1;
					a_code   = sct_pkg::SYM_INC;
				end else if (ch == "=") begin
					consumed = 1'b1;
					a_incl   = 1'b1;
					a_code   = sct_pkg::SYM_ADD_EQ;
				end else begin
					a_code = sct_pkg::SYM_ADD;
				end
			end
			sct_pkg::M_MINUS: begin
				a_valid = 1'b1;
				mode_nx = sct_pkg::M_IDLE;
				if (ch == "-") begin
					consumed = 1'b1;
					a_incl   = 1'b1;
					a_code   = sct_pkg::SYM_DECR;
				end else if (ch == "=") begin
					consumed = 1'b1;
					a_incl   = 1'b1;
					a_code   = sct_pkg::SYM_SUB_EQ;
				end else begin
					a_code = sct_pkg::SYM_SUB;
				end
			end
			sct_pkg::M_STAR: begin
				a_valid  = 1'b1;
				mode_nx  = sct_pkg::M_IDLE;
				consumed = (ch == "=");
				a_incl   = (ch == "=");
				a_code   = (ch == "=") ? sct_pkg::SYM_MUL_EQ : sct_pkg::SYM_MUL;
			end
			sct_pkg::M_PCT: begin
				a_valid  = 1'b1;
				mode_nx  = sct_pkg::M_IDLE;
				consumed = (ch == "=");
				a_incl   = (ch == "=");
				a_code   = (ch == "=") ? sct_pkg::SYM_MOD_EQ : sct_pkg::SYM_MOD;
			end
			sct_pkg::M_GT: begin
				if (ch == ">") begin
					consumed = 1'b1;
					mode_nx  = sct_pkg::M_GT2;
				end else begin
					a_valid  = 1'b1;
					mode_nx  = sct_pkg::M_IDLE;
					consumed = (ch == "=");
					a_incl   = (ch == "=");
					a_code   = (ch == "=") ? sct_pkg::SYM_GE : sct_pkg::SYM_GT;
				end
			end
			sct_pkg::M_GT2: begin
				if (ch == ">") begin
					consumed = 1'b1;
					mode_nx  = sct_pkg::M_GT3;
				end else begin
					a_valid  = 1'b1;
					mode_nx  = sct_pkg::M_IDLE;
					consumed = (ch == "=");
					a_incl   = (ch == "=");
					a_code   = (ch == "=") ? sct_pkg::SYM_SHR_EQ : sct_pkg::SYM_SHR;
				end
			end
			sct_pkg::M_GT3: begin
				a_valid  = 1'b1;
				mode_nx  = sct_pkg::M_IDLE;
				consumed = (ch == "=");
				a_incl   = (ch == "=");
				a_code   = (ch == "=") ? sct_pkg::SYM_USHR_EQ : sct_pkg::SYM_USHR;
			end
			sct_pkg::M_LT: begin
				if (ch == "<") begin
					consumed = 1'b1;
					mode_nx  = sct_pkg::M_LT2;
				end else begin
					a_valid  = 1'b1;
					mode_nx  = sct_pkg::M_IDLE;
					consumed = (ch == "=");
					a_incl   = (ch == "=");
					a_code   = (ch == "=") ? sct_pkg::SYM_LE : sct_pkg::SYM_LT;
				end
			end
			sct_pkg::M_LT2: begin
				a_valid  = 1'b1;
				mode_nx  = sct_pkg::M_IDLE;
				consumed = (ch == "=");
				a_incl   = (ch == "=");
				a_code   = (ch == "=") ? sct_pkg::SYM_SHL_EQ : sct_pkg::SYM_SHL;
			end
			sct_pkg::M_EQ: begin
				a_valid = 1'b1;
				mode_nx = sct_pkg::M_IDLE;
				if (ch == "=") begin
					consumed = 1'b1;
					a_incl   = 1'b1;
					a_code   = sct_pkg::SYM_EQ_EQ;
				end else if (ch == ">") begin
					consumed = 1'b1;
					a_incl   = 1'b1;
					a_code   = sct_pkg::SYM_ARROW;
				end else begin
					a_code = sct_pkg::SYM_ASSIGN;
				end
			end
			sct_pkg::M_BANG: begin
				a_valid  = 1'b1;
				mode_nx  = sct_pkg::M_IDLE;
				consumed = (ch == "=");
				a_incl   = (ch == "=");
				a_code   = (ch == "=") ? sct_pkg::SYM_NE : sct_pkg::SYM_NOT;
			end
			sct_pkg::M_BAR: begin
				a_valid = 1'b1;
				mode_nx = sct_pkg::M_IDLE;
				if (ch == "|") begin
					consumed = 1'b1;
					a_incl   = 1'b1;
					a_code   = sct_pkg::SYM_LOR;
				end else if (ch == "=") begin
					consumed = 1'b1;
					a_incl   = 1'b1;
					a_code   = sct_pkg::SYM_OR_EQ;
				end else begin
					a_code = sct_pkg::SYM_OR;
				end
			end
			sct_pkg::M_AMP: begin
				a_valid = 1'b1;
				mode_nx = sct_pkg::M_IDLE;
				if (ch == "&") begin
					consumed = 1'b1;
					a_incl   = 1'b1;
					a_code   = sct_pkg::SYM_LAND;
				end else if (ch == "=") begin
					consumed = 1'b1;
					a_incl   = 1'b1;
					a_code   = sct_pkg::SYM_AND_EQ;
				end else begin
					a_code = sct_pkg::SYM_AND;
				end
			end
			sct_pkg::M_CARET: begin
				a_valid  = 1'b1;
				mode_nx  = sct_pkg::M_IDLE;
				consumed = (ch == "=");
				a_incl   = (ch == "=");
				a_code   = (ch == "=") ? sct_pkg::SYM_XOR_EQ : sct_pkg::SYM_XOR;
			end
			default: begin
				mode_nx = sct_pkg::M_IDLE;
			end
		endcase

		// an open comment gives nothing at the end of the source
		if (end_of_input && (mode_q == sct_pkg::M_LCOM || mode_q == sct_pkg::M_BCOM)) begin
			a_valid = 1'b0;
		end

		// start a new token with a character that the pending token did not take
		if (!end_of_input && !consumed) begin
			if (letter || ch == sct_pkg::CH_USCORE) begin
				mode_nx = sct_pkg::M_IDENT;
			end else if (nzdigit) begin
				mode_nx = sct_pkg::M_INT;
			end else begin
				case (ch)
					"(": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_SEP;
						b_code = sct_pkg::SEP_LPAREN; end
					")": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_SEP;
						b_code = sct_pkg::SEP_RPAREN; end
					"{": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_SEP;
						b_code = sct_pkg::SEP_LBRACE; end
					"}": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_SEP;
						b_code = sct_pkg::SEP_RBRACE; end
					"[": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_SEP;
						b_code = sct_pkg::SEP_LBRACKET; end
					"]": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_SEP;
						b_code = sct_pkg::SEP_RBRACKET; end
					":": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_SEP;
						b_code = sct_pkg::SEP_COLON; end
					";": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_SEP;
						b_code = sct_pkg::SEP_SEMI; end
					",": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_SEP;
						b_code = sct_pkg::SYM_COMMA; end
					"?": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_SEP;
						b_code = sct_pkg::SYM_QUEST; end
					"~": begin b_valid = 1'b1; b_kind = sct_pkg::KIND_OP;
						b_code = sct_pkg::SYM_TILDE; end
					sct_pkg::CH_ZERO: mode_nx = sct_pkg::M_ZERO;
					".": mode_nx = sct_pkg::M_DOT;
					"/": mode_nx = sct_pkg::M_SLASH;
					"+": mode_nx = sct_pkg::M_PLUS;
					"-": mode_nx = sct_pkg::M_MINUS;
					"*": mode_nx = sct_pkg::M_STAR;
					"%": mode_nx = sct_pkg::M_PCT;
					">": mode_nx = sct_pkg::M_GT;
					"<": mode_nx = sct_pkg::M_LT;
					"=": mode_nx = sct_pkg::M_EQ;
					"!": mode_nx = sct_pkg::M_BANG;
					"|": mode_nx = sct_pkg::M_BAR;
					"&": mode_nx = sct_pkg::M_AMP;
					"^": mode_nx = sct_pkg::M_CARET;
					default: mode_nx = sct_pkg::M_IDLE;
				endcase
			end
			// whitespace and unknown bytes leave the pending start alone
			if (b_valid || mode_nx != sct_pkg::M_IDLE) begin
				p_off_nx  = here;
				p_line_nx = line_q;
				p_col_nx  = col_q;
			end
		end

		// end token after any flushed token
		if (end_of_input) begin
			b_valid = 1'b1;
			b_kind  = sct_pkg::KIND_END;
			b_code  = sct_pkg::CODE_NONE;
		end

		// advance the position counters
		off_nx  = here;
		line_nx = line_q;
		col_nx  = inc_line(col_q);
		if (ch == sct_pkg::CH_NEWLINE && !end_of_input) begin
			line_nx = inc_line(line_q);
			col_nx  = LINE_ONE;
		end

		// pack the tokens, pending one first
		a_end = a_incl ? after : here;
		ra = {!b_valid, a_end, p_col_q, p_line_q, p_off_q, a_code, a_kind};
		if (end_of_input) begin
			rb = {1'b1, here, col_q, line_q, here, b_code, b_kind};
		end else begin
			rb = {1'b1, after, col_q, line_q, here, b_code, b_kind};
		end
		push.first  = step && (a_valid || b_valid);
		push.second = step && a_valid && b_valid;
		res0 = a_valid ? ra : rb;
		res1 = rb;
	end

	// scan state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= sct_pkg::M_IDLE;
			off_q    <= '0;
			line_q   <= LINE_ONE;
			col_q    <= LINE_ONE;
			p_off_q  <= '0;
			p_line_q <= LINE_ONE;
			p_col_q  <= LINE_ONE;
			star_q   <= 1'b0;
		end else if (step) begin
			if (end_of_input) begin
				mode_q   <= sct_pkg::M_IDLE;
				off_q    <= '0;
				line_q   <= LINE_ONE;
				col_q    <= LINE_ONE;
				p_off_q  <= '0;
				p_line_q <= LINE_ONE;
				p_col_q  <= LINE_ONE;
				star_q   <= 1'b0;
			end else begin
				mode_q   <= mode_nx;
				off_q    <= off_nx;
				line_q   <= line_nx;
				col_q    <= col_nx;
				p_off_q  <= p_off_nx;
				p_line_q <= p_line_nx;
				p_col_q  <= p_col_nx;
				star_q   <= star_nx;
			end
		end
	end

endmodule

FILE: rtl/sct_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_result_fifo
// Small result queue that takes up to two tokens per cycle and hands out one
// per cycle on the master side while rd_ready is high.
// ----------------------------------------------------------------------------
module sct_result_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sct_pkg::push_t   push,
	input  logic [WIDTH-1:0] wr0,
	input  logic [WIDTH-1:0] wr1,
	output logic             room,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int DEPTH = sct_pkg::RES_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [CNT_W-1:0] count_q, push_n;
	logic             pop;

	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
	assign push_n    = CNT_W'(push.first) + CNT_W'(push.second);
	assign pop       = rd_valid && rd_ready;
	assign rd_valid  = (count_q != '0);
	assign rd_data   = mem[rd_ptr_q];
	// two free places needed before a step may run
	assign room      = (count_q <= CNT_W'(DEPTH - 2));

	// write the tokens of one step
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem[wr_ptr_q] <= wr0;
		end
		if (push.second) begin
			mem[wr_ptr_nx] <= wr1;
		end
	end

	// advance the pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + push_n - CNT_W'(pop);
		end
	end

endmodule

FILE: rtl/source_code_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_code_tokenizer
// Streaming longest-match lexer: one source character per request in, one
// token per request out, with position tracking.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                         | tuser      | tlast
//  s_*     | in        | char_in                       | -          | end_of_input
//  m_*     | out       | code, start offset/line/col,  | token_kind | is_last
//          |           | end offset                    |            |
//
// One character is taken per cycle while the queue has room; the scan step
// works on the character in the input register stage. A character that
// yields two tokens (a flushed token plus a separator, the tilde operator or
// the end token) gives two master transfers; the input stage stalls while
// the four-entry result queue has fewer than two free places. Reset clears
// the scan state, puts offset 0, line 1, column 1, and empties the queue.
// ----------------------------------------------------------------------------
module source_code_tokenizer #(
	parameter int OFFSET_BITS = sct_pkg::OFFSET_BITS_DEF,
	parameter int LINE_BITS   = sct_pkg::LINE_BITS_DEF,
	parameter int TDATA_W     = ((sct_pkg::CODE_W + 2 * OFFSET_BITS
	                              + 2 * LINE_BITS + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // char_in
	input  logic               s_tlast,   // end_of_input
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // token_code, start_offset, start_line,
	                                      // start_column, end_offset
	output logic [7:0]         m_tuser,   // token_kind
	output logic               m_tlast    // is_last
);

	localparam int RES_W = sct_pkg::KIND_W + sct_pkg::CODE_W
	                       + 2 * OFFSET_BITS + 2 * LINE_BITS + 1;

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             eoi_s1;
	logic             room, step;
	sct_pkg::push_t   push;
	logic [RES_W-1:0] res0, res1, head;

	assign step     = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	// hold the request until the scan step takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	sct_scan_core #(
		.OFFSET_BITS (OFFSET_BITS),
		.LINE_BITS   (LINE_BITS),
		.RES_W       (RES_W)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.char_in      (char_s1),
		.end_of_input (eoi_s1),
		.push         (push),
		.res0         (res0),
		.res1         (res1)
	);

	sct_result_fifo #(
		.WIDTH (RES_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr0      (res0),
		.wr1      (res1),
		.room     (room),
		.rd_valid (m_tvalid),
		.rd_ready (m_tready),
		.rd_data  (head)
	);

	// unpack the queue head onto the master side
	assign m_tuser = 8'(head[sct_pkg::KIND_W-1:0]);
	assign m_tdata = TDATA_W'(head[RES_W-2:sct_pkg::KIND_W]);
	assign m_tlast = head[RES_W-1];

endmodule
